[src/ray_triangle_closest_hit_unit_macros.svh]
// Assertion helpers for the checker file.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_UNIT_MACROS_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_UNIT_MACROS_SVH

// Property checked on aclk, suspended while aresetn is low.
`define RTCHU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on aclk at every edge, reset included.
`define RTCHU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/rtchu_pkg.sv]
package rtchu_pkg;

    // Coordinate format: signed, COORD_BITS wide. The fraction point drops out
    // of every ratio, so it has no hardware of its own.
    localparam int COORD_BITS = 16;

    localparam int FW  = 48;                // packed vector port width
    localparam int CW  = COORD_BITS;        // coordinate
    localparam int EW  = CW + 1;            // edge / offset vector element
    localparam int PW  = 2 * CW + 2;        // p = d x e2
    localparam int QW  = 2 * CW + 3;        // q = s x e1
    localparam int NW  = 3 * CW + 6;        // determinant and numerators
    localparam int TW  = 32;                // Q16.16 distance
    localparam int BW  = 17;                // Q1.16 barycentric
    localparam int IW  = 16;                // face index
    localparam int FS  = 16;                // fraction bits of the quotients
    localparam int QB  = 32;                // quotient bits per division
    localparam int DCW = $clog2(QB + 1);    // division step counter
    localparam int OVF_SHIFT = TW - 1 - FS; // t overflows when |T| >= D << this

    localparam logic [TW-1:0] T_POS_CAP = {1'b0, {(TW-1){1'b1}}};
    localparam logic [TW-1:0] T_NEG_CAP = {1'b1, {(TW-1){1'b0}}};

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;

    typedef struct packed {
        coord_t [2:0]           dir;
        edge_t  [2:0]           e1;
        edge_t  [2:0]           e2;
        edge_t  [2:0]           s;
        logic signed [TW-1:0]   t_lo;
        logic signed [TW-1:0]   t_hi;
        logic [IW-1:0]          face;
        logic                   first;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic           start;
        logic [NW-1:0]  num;
        logic [NW-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [QB-1:0]  quot;
    } div_rsp_t;

endpackage

[src/rtchu_front.sv]
module rtchu_front
    import rtchu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FW-1:0]        s_ray_origin,
    input  logic [FW-1:0]        s_ray_direction,
    input  logic signed [TW-1:0] s_t_lower,
    input  logic signed [TW-1:0] s_t_upper,
    input  logic [FW-1:0]        s_vertex_a,
    input  logic [FW-1:0]        s_vertex_b,
    input  logic [FW-1:0]        s_vertex_c,
    input  logic [IW-1:0]        s_face_index,
    input  logic                 s_first_of_ray,
    input  logic                 s_last_of_ray,
    output logic                 deq_valid,
    input  logic                 deq_ready,
    output job_t                 deq_job
);

    job_t       job_in;
    job_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    // Unpack and form the edge vectors on the way in.
    always_comb begin
        coord_t o;
        coord_t a;
        coord_t b;
        coord_t c;
        job_in = '0;
        for (int k = 0; k < 3; k++) begin
            o = s_ray_origin[k*CW +: CW];
            a = s_vertex_a[k*CW +: CW];
            b = s_vertex_b[k*CW +: CW];
            c = s_vertex_c[k*CW +: CW];
            job_in.dir[k] = s_ray_direction[k*CW +: CW];
            job_in.e1[k]  = EW'(b) - EW'(a);
            job_in.e2[k]  = EW'(c) - EW'(a);
            job_in.s[k]   = EW'(o) - EW'(a);
        end
        job_in.t_lo  = s_t_lower;
        job_in.t_hi  = s_t_upper;
        job_in.face  = s_face_index;
        job_in.first = s_first_of_ray;
        job_in.last  = s_last_of_ray;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign deq_valid = (count_reg != 2'd0);
    assign deq_job   = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = deq_valid && deq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                queue_reg[wr_ptr_reg] <= job_in;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[src/rtchu_div.sv]
module rtchu_div
    import rtchu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    // Restoring division of num * 2^FS by den, one quotient bit per cycle.
    // Caller guarantees the quotient fits in QB bits.
    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  den_reg;
    logic [QB-1:0]  shf_reg;
    logic [QB-1:0]  quot_reg;
    logic [DCW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [NW:0]    trial;
    logic [NW:0]    diff;
    logic           ge;

    assign trial = {rem_reg, shf_reg[QB-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                rem_reg  <= {{FS{1'b0}}, div_req.num[NW-1:FS]};
                shf_reg  <= {div_req.num[FS-1:0], {(QB-FS){1'b0}}};
                den_reg  <= div_req.den;
                cnt_reg  <= DCW'(QB);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[NW-1:0] : trial[NW-1:0];
                shf_reg  <= {shf_reg[QB-2:0], 1'b0};
                quot_reg <= {quot_reg[QB-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == DCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quot_reg;

endmodule

[src/rtchu_back.sv]
module rtchu_back
    import rtchu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 deq_valid,
    output logic                 deq_ready,
    input  job_t                 deq_job,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic signed [TW-1:0] m_hit_distance,
    output logic [BW-1:0]        m_bary_u,
    output logic [BW-1:0]        m_bary_v,
    output logic [IW-1:0]        m_hit_face
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS_MUL,
        ST_CROSS_SUB,
        ST_DOT_MUL,
        ST_DOT_SUM,
        ST_NORM,
        ST_CLASSIFY,
        ST_DIV_T,
        ST_TEST,
        ST_DIV_U,
        ST_DIV_V,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    job_t                 job_reg;

    logic signed [PW-1:0] cp_reg   [6];
    logic signed [QW-1:0] cq_reg   [6];
    logic signed [PW-1:0] p_reg    [3];
    logic signed [QW-1:0] q_reg    [3];
    logic signed [NW-1:0] pd_reg   [3];
    logic signed [NW-1:0] pu_reg   [3];
    logic signed [NW-1:0] pv_reg   [3];
    logic signed [NW-1:0] pt_reg   [3];
    logic signed [NW-1:0] det_reg;
    logic signed [NW-1:0] nu_reg;
    logic signed [NW-1:0] nv_reg;
    logic signed [NW-1:0] nt_reg;
    logic                 t_neg_reg;
    logic signed [TW-1:0] t_reg;
    logic [BW-1:0]        u_reg;
    logic                 div_start_reg;
    logic [NW-1:0]        div_num_reg;

    // closest-hit record
    logic signed [TW-1:0] closest_reg;
    logic                 found_reg;
    logic [BW-1:0]        best_u_reg;
    logic [BW-1:0]        best_v_reg;
    logic [IW-1:0]        best_face_reg;

    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic signed [TW-1:0] m_dist_reg;
    logic [BW-1:0]        m_u_reg;
    logic [BW-1:0]        m_v_reg;
    logic [IW-1:0]        m_face_reg;

    logic signed [PW-1:0] cp       [6];
    logic signed [QW-1:0] cq       [6];
    logic signed [NW-1:0] pd       [3];
    logic signed [NW-1:0] pu       [3];
    logic signed [NW-1:0] pv       [3];
    logic signed [NW-1:0] pt       [3];
    logic signed [NW:0]   uv_sum;
    logic                 reject;
    logic                 t_neg;
    logic [NW-1:0]        t_mag;
    logic                 t_ovf;
    logic                 t_pass;

    // cross products, one multiplier per partial product
    always_comb begin
        cp[0] = PW'(job_reg.dir[1]) * PW'(job_reg.e2[2]);
        cp[1] = PW'(job_reg.dir[2]) * PW'(job_reg.e2[1]);
        cp[2] = PW'(job_reg.dir[2]) * PW'(job_reg.e2[0]);
        cp[3] = PW'(job_reg.dir[0]) * PW'(job_reg.e2[2]);
        cp[4] = PW'(job_reg.dir[0]) * PW'(job_reg.e2[1]);
        cp[5] = PW'(job_reg.dir[1]) * PW'(job_reg.e2[0]);
        cq[0] = QW'(job_reg.s[1]) * QW'(job_reg.e1[2]);
        cq[1] = QW'(job_reg.s[2]) * QW'(job_reg.e1[1]);
        cq[2] = QW'(job_reg.s[2]) * QW'(job_reg.e1[0]);
        cq[3] = QW'(job_reg.s[0]) * QW'(job_reg.e1[2]);
        cq[4] = QW'(job_reg.s[0]) * QW'(job_reg.e1[1]);
        cq[5] = QW'(job_reg.s[1]) * QW'(job_reg.e1[0]);
    end

    // dot product terms
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pd[k] = NW'(p_reg[k]) * NW'(job_reg.e1[k]);
            pu[k] = NW'(job_reg.s[k]) * NW'(p_reg[k]);
            pv[k] = NW'(job_reg.dir[k]) * NW'(q_reg[k]);
            pt[k] = NW'(job_reg.e2[k]) * NW'(q_reg[k]);
        end
    end

    // inside test on the sign-normalized numerators
    assign uv_sum = (NW+1)'(nu_reg) + (NW+1)'(nv_reg);
    assign reject = (det_reg == '0) || nu_reg[NW-1] || (nu_reg > det_reg) ||
                    nv_reg[NW-1] || (uv_sum > (NW+1)'(det_reg));
    assign t_neg  = nt_reg[NW-1];
    assign t_mag  = t_neg ? -nt_reg : nt_reg;
    assign t_ovf  = ({{OVF_SHIFT{1'b0}}, t_mag} >= {det_reg, {OVF_SHIFT{1'b0}}});
    assign t_pass = (t_reg >= $signed(job_reg.t_lo)) && (t_reg <= $signed(job_reg.t_hi)) &&
                    (t_reg <= closest_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            closest_reg   <= '0;
            found_reg     <= 1'b0;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            best_face_reg <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (deq_valid) begin
                        job_reg <= deq_job;
                        if (deq_job.first) begin
                            closest_reg   <= $signed(deq_job.t_hi);
                            found_reg     <= 1'b0;
                            best_u_reg    <= '0;
                            best_v_reg    <= '0;
                            best_face_reg <= '0;
                        end
                        state_reg <= ST_CROSS_MUL;
                    end
                end
                ST_CROSS_MUL: begin
                    for (int k = 0; k < 6; k++) begin
                        cp_reg[k] <= cp[k];
                        cq_reg[k] <= cq[k];
                    end
                    state_reg <= ST_CROSS_SUB;
                end
                ST_CROSS_SUB: begin
                    for (int k = 0; k < 3; k++) begin
                        p_reg[k] <= cp_reg[2*k] - cp_reg[2*k+1];
                        q_reg[k] <= cq_reg[2*k] - cq_reg[2*k+1];
                    end
                    state_reg <= ST_DOT_MUL;
                end
                ST_DOT_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        pd_reg[k] <= pd[k];
                        pu_reg[k] <= pu[k];
                        pv_reg[k] <= pv[k];
                        pt_reg[k] <= pt[k];
                    end
                    state_reg <= ST_DOT_SUM;
                end
                ST_DOT_SUM: begin
                    det_reg   <= pd_reg[0] + pd_reg[1] + pd_reg[2];
                    nu_reg    <= pu_reg[0] + pu_reg[1] + pu_reg[2];
                    nv_reg    <= pv_reg[0] + pv_reg[1] + pv_reg[2];
                    nt_reg    <= pt_reg[0] + pt_reg[1] + pt_reg[2];
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    // make the determinant non-negative
                    if (det_reg[NW-1]) begin
                        det_reg <= -det_reg;
                        nu_reg  <= -nu_reg;
                        nv_reg  <= -nv_reg;
                        nt_reg  <= -nt_reg;
                    end
                    state_reg <= ST_CLASSIFY;
                end
                ST_CLASSIFY: begin
                    t_neg_reg <= t_neg;
                    if (reject) begin
                        state_reg <= ST_EMIT;
                    end else if (t_ovf) begin
                        t_reg     <= t_neg ? T_NEG_CAP : T_POS_CAP;
                        state_reg <= ST_TEST;
                    end else begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= t_mag;
                        state_reg     <= ST_DIV_T;
                    end
                end
                ST_DIV_T: begin
                    if (div_rsp.done) begin
                        t_reg     <= t_neg_reg ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (t_pass) begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= nu_reg;
                        state_reg     <= ST_DIV_U;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_DIV_U: begin
                    if (div_rsp.done) begin
                        u_reg         <= div_rsp.quot[BW-1:0];
                        div_start_reg <= 1'b1;
                        div_num_reg   <= nv_reg;
                        state_reg     <= ST_DIV_V;
                    end
                end
                ST_DIV_V: begin
                    if (div_rsp.done) begin
                        closest_reg   <= t_reg;
                        found_reg     <= 1'b1;
                        best_u_reg    <= u_reg;
                        best_v_reg    <= div_rsp.quot[BW-1:0];
                        best_face_reg <= job_reg.face;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!job_reg.last) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_hit_reg   <= found_reg;
                        m_dist_reg  <= found_reg ? closest_reg : '0;
                        m_u_reg     <= found_reg ? best_u_reg : '0;
                        m_v_reg     <= found_reg ? best_v_reg : '0;
                        m_face_reg  <= found_reg ? best_face_reg : '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign deq_ready     = (state_reg == ST_IDLE);
    assign div_req.start = div_start_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = det_reg;

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_hit_distance = m_dist_reg;
    assign m_bary_u       = m_u_reg;
    assign m_bary_v       = m_v_reg;
    assign m_hit_face     = m_face_reg;

endmodule

[src/ray_triangle_closest_hit_unit.sv]
// Closest-hit ray/triangle unit (Moller-Trumbore, exact integer arithmetic).
// Each request carries one ray and one triangle; requests of a ray arrive in
// order, the first marked first_of_ray and the last marked last_of_ray, and
// the last one returns the closest hit (t in Q16.16, u and v in Q1.16, face).
// A triangle rejected by the determinant or the inside test runs the states
// IDLE to CLASSIFY and then EMIT; one whose t falls out of range adds the t
// division and TEST, and an accepted one adds the u and v divisions: the three
// quotients t, u and v share one restoring divider that produces one bit per
// cycle. A saturated t skips its division. A two-deep request queue sits in
// front of the sequencer and the result sits in an output register, so new
// requests are taken while a result waits on m_ready.
module ray_triangle_closest_hit_unit
    import rtchu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FW-1:0]        s_ray_origin,
    input  logic [FW-1:0]        s_ray_direction,
    input  logic signed [TW-1:0] s_t_lower,
    input  logic signed [TW-1:0] s_t_upper,
    input  logic [FW-1:0]        s_vertex_a,
    input  logic [FW-1:0]        s_vertex_b,
    input  logic [FW-1:0]        s_vertex_c,
    input  logic [IW-1:0]        s_face_index,
    input  logic                 s_first_of_ray,
    input  logic                 s_last_of_ray,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic signed [TW-1:0] m_hit_distance,
    output logic [BW-1:0]        m_bary_u,
    output logic [BW-1:0]        m_bary_v,
    output logic [IW-1:0]        m_hit_face
);

    logic     deq_valid;
    logic     deq_ready;
    job_t     deq_job;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // front end: unpack, edge vectors, request queue
    rtchu_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ray_origin    (s_ray_origin),
        .s_ray_direction (s_ray_direction),
        .s_t_lower       (s_t_lower),
        .s_t_upper       (s_t_upper),
        .s_vertex_a      (s_vertex_a),
        .s_vertex_b      (s_vertex_b),
        .s_vertex_c      (s_vertex_c),
        .s_face_index    (s_face_index),
        .s_first_of_ray  (s_first_of_ray),
        .s_last_of_ray   (s_last_of_ray),
        .deq_valid       (deq_valid),
        .deq_ready       (deq_ready),
        .deq_job         (deq_job)
    );

    // shared quotient unit for t, u and v
    rtchu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // back end: cross/dot products, tests, closest-hit record, result register
    rtchu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .deq_valid      (deq_valid),
        .deq_ready      (deq_ready),
        .deq_job        (deq_job),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_hit_distance (m_hit_distance),
        .m_bary_u       (m_bary_u),
        .m_bary_v       (m_bary_v),
        .m_hit_face     (m_hit_face)
    );

endmodule

[src/rtchu_checker.sv]
`include "ray_triangle_closest_hit_unit_macros.svh"

module rtchu_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [47:0]       s_ray_origin,
    input logic [47:0]       s_ray_direction,
    input logic signed [31:0] s_t_lower,
    input logic signed [31:0] s_t_upper,
    input logic [47:0]       s_vertex_a,
    input logic [47:0]       s_vertex_b,
    input logic [47:0]       s_vertex_c,
    input logic [15:0]       s_face_index,
    input logic              s_first_of_ray,
    input logic              s_last_of_ray,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_hit,
    input logic signed [31:0] m_hit_distance,
    input logic [16:0]       m_bary_u,
    input logic [16:0]       m_bary_v,
    input logic [15:0]       m_hit_face
);

    `RTCHU_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_hit_distance) && $stable(m_hit_face), "result dropped or changed while stalled")
    `RTCHU_ASSERT(a_miss_zero, m_valid && !m_hit |-> m_hit_distance == 32'sd0 && m_bary_u == 17'd0 && m_bary_v == 17'd0 && m_hit_face == 16'd0, "miss result not zero")
    `RTCHU_ASSERT(a_bary_sum, m_valid && m_hit |-> ({1'b0, m_bary_u} + {1'b0, m_bary_v}) <= 18'd65536, "barycentrics exceed one")
    `RTCHU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind ray_triangle_closest_hit_unit rtchu_checker u_rtchu_checker (.*);

[sim/tb_ray_triangle_closest_hit_unit.sv]
`timescale 1ns / 100ps

// Testbench for the closest-hit ray/triangle unit.
// A stream of triangle tests grouped into rays is sent. An in-bench integer
// model keeps the closest-hit record and queues one expected hit report per
// last_of_ray request. A checker compares every report the block returns.
module tb_ray_triangle_closest_hit_unit;
    import rtchu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
    localparam int LONG_HOLD      = 3000;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 300;    // wait after the last drain, in cycles

    typedef logic signed [127:0] wide_t;

    // One request: a ray plus one triangle.
    typedef struct {
        logic [FW-1:0]        origin;
        logic [FW-1:0]        direction;
        logic signed [TW-1:0] t_lo;
        logic signed [TW-1:0] t_hi;
        logic [FW-1:0]        va;
        logic [FW-1:0]        vb;
        logic [FW-1:0]        vc;
        logic [IW-1:0]        face;
        logic                 first;
        logic                 last;
    } tri_req_t;

    // One hit report.
    typedef struct {
        logic                 hit;
        logic signed [TW-1:0] distance;
        logic [BW-1:0]        u;
        logic [BW-1:0]        v;
        logic [IW-1:0]        face;
    } hit_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FW-1:0]        s_ray_origin = '0;
    logic [FW-1:0]        s_ray_direction = '0;
    logic signed [TW-1:0] s_t_lower = '0;
    logic signed [TW-1:0] s_t_upper = '0;
    logic [FW-1:0]        s_vertex_a = '0;
    logic [FW-1:0]        s_vertex_b = '0;
    logic [FW-1:0]        s_vertex_c = '0;
    logic [IW-1:0]        s_face_index = '0;
    logic                 s_first_of_ray = 1'b0;
    logic                 s_last_of_ray = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_hit;
    logic signed [TW-1:0] m_hit_distance;
    logic [BW-1:0]        m_bary_u;
    logic [BW-1:0]        m_bary_v;
    logic [IW-1:0]        m_hit_face;

    ray_triangle_closest_hit_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ray_origin    (s_ray_origin),
        .s_ray_direction (s_ray_direction),
        .s_t_lower       (s_t_lower),
        .s_t_upper       (s_t_upper),
        .s_vertex_a      (s_vertex_a),
        .s_vertex_b      (s_vertex_b),
        .s_vertex_c      (s_vertex_c),
        .s_face_index    (s_face_index),
        .s_first_of_ray  (s_first_of_ray),
        .s_last_of_ray   (s_last_of_ray),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_hit_distance  (m_hit_distance),
        .m_bary_u        (m_bary_u),
        .m_bary_v        (m_bary_v),
        .m_hit_face      (m_hit_face)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Closest-hit record as the block should hold it (reset: all zero).
    logic signed [63:0] rec_t = '0;
    logic               rec_found = 1'b0;
    logic [BW-1:0]      rec_u = '0;
    logic [BW-1:0]      rec_v = '0;
    logic [IW-1:0]      rec_face = '0;

    hit_report_t pending_hits[$];
    int          errors = 0;
    int          hold_cycles = 0;   // receiver hold-off request
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    // ---------------------------------------------------------------
    // Integer Moller-Trumbore model
    // ---------------------------------------------------------------
    function automatic wide_t coord(logic [FW-1:0] w, int k);
        logic signed [CW-1:0] c;
        c = w[k*CW +: CW];
        return wide_t'(c);
    endfunction

    // floor(m * 2^16 / den), m >= 0, den > 0, clamped to cap
    function automatic wide_t frac_quot(wide_t m, wide_t den, wide_t cap);
        wide_t q;
        q = (m <<< FS) / den;
        return (q > cap) ? cap : q;
    endfunction

    function automatic void update_record(tri_req_t r);
        wide_t o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], s[3], p[3], q[3];
        wide_t det, nu, nv, nt, mag, tq, tval;
        if (r.first) begin
            rec_t     = 64'(r.t_hi);
            rec_found = 1'b0;
            rec_u     = '0;
            rec_v     = '0;
            rec_face  = '0;
        end
        for (int k = 0; k < 3; k++) begin
            o[k]  = coord(r.origin, k);
            d[k]  = coord(r.direction, k);
            a[k]  = coord(r.va, k);
            b[k]  = coord(r.vb, k);
            c[k]  = coord(r.vc, k);
            e1[k] = b[k] - a[k];
            e2[k] = c[k] - a[k];
            s[k]  = o[k] - a[k];
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
        nu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
        nv  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0) begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        if (det != 0 && nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det) begin
            mag  = (nt < 0) ? -nt : nt;
            tq   = frac_quot(mag, det, (nt < 0) ? wide_t'(64'h8000_0000)
                                                : wide_t'(64'h7fff_ffff));
            tval = (nt < 0) ? -tq : tq;
            if (tval >= r.t_lo && tval <= r.t_hi && tval <= rec_t) begin
                rec_t     = 64'(tval);
                rec_found = 1'b1;
                rec_u     = BW'(frac_quot(nu, det, wide_t'(65536)));
                rec_v     = BW'(frac_quot(nv, det, wide_t'(65536)));
                rec_face  = r.face;
            end
        end
        if (r.last) begin
            hit_report_t h;
            h.hit      = rec_found;
            h.distance = rec_found ? rec_t[TW-1:0] : '0;
            h.u        = rec_found ? rec_u : '0;
            h.v        = rec_found ? rec_v : '0;
            h.face     = rec_found ? rec_face : '0;
            pending_hits.push_back(h);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Call right after a rising edge; returns at the edge that took the request, or after the gap that follows it.
    task automatic send_request(tri_req_t r);
        s_valid         <= 1'b1;
        s_ray_origin    <= r.origin;
        s_ray_direction <= r.direction;
        s_t_lower       <= r.t_lo;
        s_t_upper       <= r.t_hi;
        s_vertex_a      <= r.va;
        s_vertex_b      <= r.vb;
        s_vertex_c      <= r.vc;
        s_face_index    <= r.face;
        s_first_of_ray  <= r.first;
        s_last_of_ray   <= r.last;
        do @(posedge aclk); while (!s_ready);
        update_record(r);
        // bursty sender: random gaps between bursts of back-to-back requests
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic logic [FW-1:0] vec3(int x, int y, int z);
        logic [CW-1:0] xs, ys, zs;
        xs = CW'(x);
        ys = CW'(y);
        zs = CW'(z);
        return {zs, ys, xs};
    endfunction

    function automatic tri_req_t mk_req(logic [FW-1:0] o, logic [FW-1:0] d,
                                        int tl, int th, logic [FW-1:0] a,
                                        logic [FW-1:0] b, logic [FW-1:0] c,
                                        int face, bit first, bit last);
        tri_req_t r;
        r.origin = o; r.direction = d; r.t_lo = tl; r.t_hi = th;
        r.va = a; r.vb = b; r.vc = c; r.face = IW'(face);
        r.first = first; r.last = last;
        return r;
    endfunction

    function automatic logic [FW-1:0] rand_vec48();
        return FW'({$urandom(), $urandom()});
    endfunction

    function automatic logic [FW-1:0] small_vec(int span);
        return vec3($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                    $urandom_range(0, 2*span) - span);
    endfunction

    // Random request; mostly small geometry so that hits are common.
    function automatic tri_req_t rand_req(bit first, bit last);
        tri_req_t r;
        if ($urandom_range(0, 9) < 8) begin
            r.origin    = small_vec(300);
            r.direction = small_vec(400);
            r.va        = small_vec(600);
            r.vb        = small_vec(600);
            r.vc        = small_vec(600);
            r.t_lo      = ($urandom_range(0, 3) == 0) ? -$urandom_range(0, 1 << 20)
                                                      : $urandom_range(0, 1 << 14);
            r.t_hi      = ($urandom_range(0, 7) == 0) ? $urandom()
                                                      : $urandom_range(0, 1 << 20);
        end else begin
            r.origin    = rand_vec48();
            r.direction = rand_vec48();
            r.va        = rand_vec48();
            r.vb        = rand_vec48();
            r.vc        = rand_vec48();
            r.t_lo      = $urandom();
            r.t_hi      = $urandom();
        end
        r.face  = IW'($urandom());
        r.first = first;
        r.last  = last;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Ray along +z through a unit triangle at z = 2: t = 2.0
    logic [FW-1:0] base_a, base_b, base_c, zdir;

    task automatic test_directed();
        logic [FW-1:0] zero;
        zero   = vec3(0, 0, 0);
        base_a = vec3(-256, -256, 512);
        base_b = vec3(256, -256, 512);
        base_c = vec3(0, 256, 512);
        zdir   = vec3(0, 0, 256);
        // no ray start after reset: record holds closest t = 0, origin on plane
        send_request(mk_req(vec3(0, 0, 512), zdir, -65536, 65536,
                            base_a, base_b, base_c, 1, 1'b0, 1'b1));
        // plain hit
        send_request(mk_req(zero, zdir, 0, 32'h0010_0000, base_a, base_b, base_c,
                            2, 1'b1, 1'b1));
        // ray through vertex b: u = 1, v = 0
        send_request(mk_req(vec3(256, -256, 0), zdir, 0, 32'h0010_0000,
                            base_a, base_b, base_c, 3, 1'b1, 1'b1));
        // outside, degenerate triangle, parallel ray
        send_request(mk_req(vec3(1024, 0, 0), zdir, 0, 32'h0010_0000,
                            base_a, base_b, base_c, 4, 1'b1, 1'b0));
        send_request(mk_req(zero, zdir, 0, 32'h0010_0000, base_a, base_a, base_c,
                            5, 1'b0, 1'b0));
        send_request(mk_req(zero, vec3(256, 0, 0), 0, 32'h0010_0000,
                            base_a, base_b, base_c, 6, 1'b0, 1'b1));
        // t below t_lower, above t_upper, inverted range
        send_request(mk_req(zero, zdir, 32'h0003_0000, 32'h0010_0000,
                            base_a, base_b, base_c, 7, 1'b1, 1'b1));
        send_request(mk_req(zero, zdir, 0, 32'h0001_0000, base_a, base_b, base_c,
                            8, 1'b1, 1'b1));
        send_request(mk_req(zero, zdir, 32'h0010_0000, 0, base_a, base_b, base_c,
                            9, 1'b1, 1'b1));
        // farther, then closer, then a tie: the later tie wins
        send_request(mk_req(zero, zdir, 0, 32'h0010_0000, vec3(-256, -256, 1024),
                            vec3(256, -256, 1024), vec3(0, 256, 1024), 10, 1'b1, 1'b0));
        send_request(mk_req(zero, zdir, 0, 32'h0010_0000, base_a, base_b, base_c,
                            11, 1'b0, 1'b0));
        send_request(mk_req(zero, zdir, 0, 32'h0010_0000, base_c, base_a, base_b,
                            12, 1'b0, 1'b1));
        // report again without a new ray start: record is kept
        send_request(mk_req(vec3(1024, 0, 0), zdir, 0, 0, base_a, base_b, base_c,
                            13, 1'b0, 1'b1));
        // hit behind the origin with a negative t range
        send_request(mk_req(vec3(0, 0, 1024), zdir, 32'h8000_0000, 0,
                            base_a, base_b, base_c, 14, 1'b1, 1'b1));
        // large positive and negative t (32512.0 and -32512.0), short of saturation
        send_request(mk_req(zero, vec3(0, 0, 1), 0, 32'h7fff_ffff,
                            vec3(-256, -256, 32512), vec3(256, -256, 32512),
                            vec3(0, 256, 32512), 15, 1'b1, 1'b1));
        send_request(mk_req(zero, vec3(0, 0, -1), 32'h8000_0000, 32'h7fff_ffff,
                            vec3(-256, -256, 32512), vec3(256, -256, 32512),
                            vec3(0, 256, 32512), 16, 1'b1, 1'b1));
        // coordinate extremes, all-ones face
        send_request(mk_req(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
                            32'h8000_0000, 32'h7fff_ffff, vec3(32767, -32768, 32767),
                            vec3(-32768, 32767, 32767), vec3(32767, 32767, -32768),
                            16'hffff, 1'b1, 1'b1));
        send_request(mk_req({FW{1'b1}}, {FW{1'b1}}, 32'hffff_ffff, 32'hffff_ffff,
                            {FW{1'b1}}, '0, {FW{1'b1}}, 16'hffff, 1'b1, 1'b1));
    endtask

    // Rays of 1..6 triangles; some rays lack a start or an end marker or carry an extra one.
    task automatic test_random_rays(int n_req);
        int sent;
        int len;
        bit first;
        bit last;
        sent = 0;
        while (sent < n_req) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                first = (i == 0);
                last  = (i == len - 1);
                if ($urandom_range(0, 19) == 0) first = ~first;
                if ($urandom_range(0, 19) == 0) last  = ~last;
                send_request(rand_req(first, last));
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        hold_cycles = LONG_HOLD;
        gaps_on = 1'b0;
        for (int i = 0; i < 40; i++) send_request(rand_req(1'b1, 1'b1));
        gaps_on = 1'b1;
    endtask

    // Sender pauses until every report is back.
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, switching between stall and free-run phases
    // ---------------------------------------------------------------
    initial begin
        bit stall_phase;
        int phase_left;
        stall_phase = 1'b0;
        phase_left  = 100;
        forever begin
            @(posedge aclk);
            if (phase_left == 0) begin
                stall_phase = ~stall_phase;
                phase_left  = $urandom_range(20, 300);
            end else begin
                phase_left--;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= stall_phase ? ($urandom_range(0, 2) == 0) : 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Report checker
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected report hit=%0b t=%h face=%h", $realtime,
                         m_hit, m_hit_distance, m_hit_face);
                errors++;
            end else begin
                hit_report_t h;
                h = pending_hits.pop_front();
                if (m_hit !== h.hit) begin
                    $display("%0t: hit exp %0b got %0b", $realtime, h.hit, m_hit);
                    errors++;
                end
                if (m_hit_distance !== h.distance) begin
                    $display("%0t: hit_distance exp %h got %h", $realtime, h.distance,
                             m_hit_distance);
                    errors++;
                end
                if (m_bary_u !== h.u) begin
                    $display("%0t: bary_u exp %h got %h", $realtime, h.u, m_bary_u);
                    errors++;
                end
                if (m_bary_v !== h.v) begin
                    $display("%0t: bary_v exp %h got %h", $realtime, h.v, m_bary_v);
                    errors++;
                end
                if (m_hit_face !== h.face) begin
                    $display("%0t: hit_face exp %h got %h", $realtime, h.face, m_hit_face);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request nor a report taken.
    int idle_count = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb_ray_triangle_closest_hit_unit: done, errors");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_drain_pause();
        test_random_rays(500);
        test_output_backpressure();
        test_drain_pause();
        test_random_rays(650);
        test_drain_pause();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_ray_triangle_closest_hit_unit: done, clean");
        end else begin
            $display("tb_ray_triangle_closest_hit_unit: done, errors");
        end
        $finish;
    end

endmodule
